### hw/rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

   // defaults for the top level parameters
   localparam int unsigned MAX_BLOCKS_DEF   = 64;
   localparam int unsigned HEADER_BYTES_DEF = 40;
   localparam int unsigned CANARY_BYTES_DEF = 4;

   // fixed field widths
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned SIZE_W = 24;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned LIVE_W = 7;

   // request commands
   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_NO_SPACE    = 2'd1,
      STAT_DOUBLE_FREE = 2'd2,
      STAT_UNKNOWN_PTR = 2'd3
   } status_type;

   // register map
   typedef enum logic {
      REG_HEAP_BASE  = 1'b0,
      REG_HEAP_LIMIT = 1'b1
   } reg_type;

   // one block table entry
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic              used;
   } entry_type;

   // request held while the table is scanned
   typedef struct packed {
      cmd_type           cmd;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] addr;
   } query_type;

   // user data address of a block, one bit wider so it never wraps
   function automatic logic [ADDR_W:0] user_of(input logic [ADDR_W-1:0] start,
                                               input logic [ADDR_W:0]   ofs);
      return {1'b0, start} + ofs;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ffba_ram.sv
`default_nettype none

module ffba_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ffba_match.sv
`default_nettype none

module ffba_match #(
   parameter int unsigned HEADER_BYTES = 40,
   parameter int unsigned CANARY_BYTES = 4
) (
   input  wire ffba_pkg::query_type query,
   input  wire ffba_pkg::entry_type entry,
   output logic                     hit
);

   import ffba_pkg::*;

   localparam logic [ADDR_W:0] USER_OFS = (ADDR_W+1)'(HEADER_BYTES + CANARY_BYTES);

   // alloc wants a free entry that is big enough, free wants the matching address
   always_comb begin
      unique case (query.cmd)
         CMD_ALLOC: hit = !entry.used && (query.size <= entry.size);
         CMD_FREE:  hit = (user_of(entry.start, USER_OFS) == {1'b0, query.addr});
         default:   hit = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/first_fit_block_allocator.sv
`default_nettype none

// channel   ports                                       handshake
// -------   -----------------------------------------   ------------------------------
// request   req_cmd, req_size, req_user_addr            taken when start && !busy
// response  rsp_status .. rsp_bytes_freed               valid for one cycle on rsp_valid
// csr       csr_index, csr_wdata                        written when csr_valid && csr_ready
//
// a request scans the block table one entry per cycle through the single read port of
// the table memory, until an entry matches or the table is exhausted
// a null free answers in the cycle after it is taken without raising busy
// the response appears the cycle after the deciding scan cycle and cannot be stalled
// synchronous active-high reset clears control and counters; the table is not cleared

module first_fit_block_allocator #(
   parameter int unsigned MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
   parameter int unsigned CANARY_BYTES = ffba_pkg::CANARY_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_cmd,
   input  wire logic [ffba_pkg::SIZE_W-1:0]   req_size,
   input  wire logic [ffba_pkg::ADDR_W-1:0]   req_user_addr,
   output logic                               rsp_valid,
   output logic      [ffba_pkg::STAT_W-1:0]   rsp_status,
   output logic      [ffba_pkg::ADDR_W-1:0]   rsp_grant_addr,
   output logic                               rsp_reused,
   output logic      [ffba_pkg::LIVE_W-1:0]   rsp_live_blocks,
   output logic      [ffba_pkg::ADDR_W-1:0]   rsp_bytes_allocated,
   output logic      [ffba_pkg::ADDR_W-1:0]   rsp_bytes_freed,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_index,
   input  wire logic [ffba_pkg::ADDR_W-1:0]   csr_wdata
);

   import ffba_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned LW    = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
   localparam logic [ADDR_W:0] USER_OFS = (ADDR_W+1)'(HEADER_BYTES + CANARY_BYTES);
   localparam logic [ADDR_W:0] BLK_OVH  = (ADDR_W+1)'(HEADER_BYTES + 2 * CANARY_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   query_type             query_ff, query_in;
   logic [CNT_W-1:0]      issue_idx_ff, issue_idx_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]      block_count_ff, block_count_in;
   logic [ADDR_W-1:0]     heap_top_ff, heap_top_in;
   logic [ADDR_W-1:0]     heap_limit_ff, heap_limit_in;
   logic [CNT_W-1:0]      active_ff, active_in;
   logic [ADDR_W-1:0]     alloc_total_ff, alloc_total_in;
   logic [ADDR_W-1:0]     freed_total_ff, freed_total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]     rsp_grant_ff, rsp_grant_in;
   logic                  rsp_reused_ff, rsp_reused_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   entry_type             ram_wdata;
   logic                  ram_re;
   logic [IDX_W-1:0]      ram_raddr;
   entry_type             rd_entry;
   logic                  hit;

   logic [ADDR_W:0]       new_top;
   logic [ADDR_W:0]       alloc_sum;
   logic [ADDR_W:0]       freed_sum;
   logic [ADDR_W:0]       grant_full;
   logic [LW-1:0]         live_ext;

   // block table
   ffba_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_entry)
   );

   // shared entry compare
   ffba_match #(
      .HEADER_BYTES (HEADER_BYTES),
      .CANARY_BYTES (CANARY_BYTES)
   ) u_match (
      .query (query_ff),
      .entry (rd_entry),
      .hit   (hit)
   );

   // arithmetic on the held request
   assign new_top    = {1'b0, heap_top_ff} + BLK_OVH + (ADDR_W+1)'(query_ff.size);
   assign alloc_sum  = {1'b0, alloc_total_ff} + (ADDR_W+1)'(query_ff.size);
   assign freed_sum  = {1'b0, freed_total_ff} + (ADDR_W+1)'(rd_entry.size);
   assign grant_full = user_of((chk_vld_ff ? rd_entry.start : heap_top_ff), USER_OFS);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      query_in       = query_ff;
      issue_idx_in   = issue_idx_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = chk_idx_ff;
      block_count_in = block_count_ff;
      heap_top_in    = heap_top_ff;
      heap_limit_in  = heap_limit_ff;
      active_in      = active_ff;
      alloc_total_in = alloc_total_ff;
      freed_total_in = freed_total_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_grant_in   = rsp_grant_ff;
      rsp_reused_in  = rsp_reused_ff;
      ram_we         = 1'b0;
      ram_waddr      = chk_idx_ff;
      ram_wdata      = rd_entry;
      ram_re         = 1'b0;
      ram_raddr      = issue_idx_ff[IDX_W-1:0];

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_HEAP_BASE: begin
               if (block_count_ff == '0) begin
                  heap_top_in = csr_wdata;
               end
            end
            REG_HEAP_LIMIT: heap_limit_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               query_in.cmd  = cmd_type'(req_cmd);
               query_in.size = req_size;
               query_in.addr = req_user_addr;
               if (req_cmd == CMD_FREE && req_user_addr == '0) begin
                  // null free is answered at once
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_grant_in  = '0;
                  rsp_reused_in = 1'b0;
               end else begin
                  state_in = ST_SCAN;
                  if (block_count_ff != '0) begin
                     ram_re       = 1'b1;
                     ram_raddr    = '0;
                     chk_vld_in   = 1'b1;
                     chk_idx_in   = '0;
                     issue_idx_in = CNT_W'(1);
                  end
               end
            end
         end

         ST_SCAN: begin
            // keep one read in flight per cycle
            if (issue_idx_ff < block_count_ff) begin
               ram_re       = 1'b1;
               ram_raddr    = issue_idx_ff[IDX_W-1:0];
               chk_vld_in   = 1'b1;
               chk_idx_in   = issue_idx_ff[IDX_W-1:0];
               issue_idx_in = issue_idx_ff + CNT_W'(1);
            end

            if (chk_vld_ff && hit) begin
               // entry found
               state_in      = ST_IDLE;
               chk_vld_in    = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_grant_in  = '0;
               rsp_reused_in = 1'b0;
               if (query_ff.cmd == CMD_ALLOC) begin
                  ram_we         = 1'b1;
                  ram_waddr      = chk_idx_ff;
                  ram_wdata      = '{start: rd_entry.start, size: query_ff.size, used: 1'b1};
                  active_in      = active_ff + CNT_W'(1);
                  rsp_grant_in   = grant_full[ADDR_W-1:0];
                  rsp_reused_in  = 1'b1;
               end else if (rd_entry.used) begin
                  ram_we         = 1'b1;
                  ram_waddr      = chk_idx_ff;
                  ram_wdata      = '{start: rd_entry.start, size: rd_entry.size, used: 1'b0};
                  freed_total_in = freed_sum[ADDR_W] ? '1 : freed_sum[ADDR_W-1:0];
                  if (active_ff != '0) begin
                     active_in = active_ff - CNT_W'(1);
                  end
               end else begin
                  rsp_status_in = STAT_DOUBLE_FREE;
               end
            end else if (!chk_vld_ff) begin
               // table exhausted without a match
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_grant_in  = '0;
               rsp_reused_in = 1'b0;
               if (query_ff.cmd == CMD_ALLOC) begin
                  if (block_count_ff == CNT_W'(MAX_BLOCKS) ||
                      new_top > {1'b0, heap_limit_ff}) begin
                     rsp_status_in = STAT_NO_SPACE;
                  end else begin
                     // append a fresh block at the heap top
                     rsp_status_in  = STAT_OK;
                     ram_we         = 1'b1;
                     ram_waddr      = block_count_ff[IDX_W-1:0];
                     ram_wdata      = '{start: heap_top_ff, size: query_ff.size, used: 1'b1};
                     block_count_in = block_count_ff + CNT_W'(1);
                     heap_top_in    = new_top[ADDR_W-1:0];
                     alloc_total_in = alloc_sum[ADDR_W] ? '1 : alloc_sum[ADDR_W-1:0];
                     active_in      = active_ff + CNT_W'(1);
                     rsp_grant_in   = grant_full[ADDR_W-1:0];
                  end
               end else begin
                  rsp_status_in = STAT_UNKNOWN_PTR;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         chk_vld_ff     <= 1'b0;
         block_count_ff <= '0;
         heap_top_ff    <= '0;
         heap_limit_ff  <= '1;
         active_ff      <= '0;
         alloc_total_ff <= '0;
         freed_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         chk_vld_ff     <= chk_vld_in;
         block_count_ff <= block_count_in;
         heap_top_ff    <= heap_top_in;
         heap_limit_ff  <= heap_limit_in;
         active_ff      <= active_in;
         alloc_total_ff <= alloc_total_in;
         freed_total_ff <= freed_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      issue_idx_ff  <= issue_idx_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_reused_ff <= rsp_reused_in;
   end

   // outputs
   always_comb begin
      live_ext        = LW'(active_ff);
      rsp_live_blocks = (live_ext > LW'({LIVE_W{1'b1}})) ? '1 : live_ext[LIVE_W-1:0];
   end

   assign busy                = (state_ff != ST_IDLE);
   assign csr_ready           = !busy;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_grant_addr      = rsp_grant_ff;
   assign rsp_reused          = rsp_reused_ff;
   assign rsp_bytes_allocated = alloc_total_ff;
   assign rsp_bytes_freed     = freed_total_ff;

   // checks
   a_taken_request_progresses: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("request taken but neither scanning nor answered");

   a_scan_end_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !chk_vld_ff) |=> (rsp_valid && !busy))
      else $error("exhausted scan did not answer");

   a_active_within_table: assert property (@(posedge clock) disable iff (reset)
      active_ff <= block_count_ff)
      else $error("more live blocks than table entries");

   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      block_count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count beyond table size");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import ffba_pkg::*;

   localparam int unsigned MAX_BLOCKS     = MAX_BLOCKS_DEF;
   localparam int unsigned HEADER_BYTES   = HEADER_BYTES_DEF;
   localparam int unsigned CANARY_BYTES   = CANARY_BYTES_DEF;
   localparam int unsigned USER_OFS       = HEADER_BYTES + CANARY_BYTES;
   localparam int unsigned BLOCK_OVERHEAD = HEADER_BYTES + 2 * CANARY_BYTES;
   localparam int unsigned SETTLE_CYCLES  = MAX_BLOCKS + 8;
   localparam int unsigned CYCLE_LIMIT    = 1_000_000;
   localparam int unsigned SAT_ROUNDS     = 270;
   localparam int unsigned RANDOM_ROUNDS  = 4;
   localparam int unsigned ROUND_ITEMS    = 275;

   // one expected response
   typedef struct {
      status_type        status;
      logic [ADDR_W-1:0] grant;
      logic              reused;
      logic [LIVE_W-1:0] live;
      logic [ADDR_W-1:0] bytes_alloc;
      logic [ADDR_W-1:0] bytes_freed;
   } alloc_response_type;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              start         = 1'b0;
   logic              req_cmd       = 1'b0;
   logic [SIZE_W-1:0] req_size      = '0;
   logic [ADDR_W-1:0] req_user_addr = '0;
   logic              csr_valid     = 1'b0;
   logic              csr_index     = 1'b0;
   logic [ADDR_W-1:0] csr_wdata     = '0;
   logic              busy;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [ADDR_W-1:0] rsp_grant_addr;
   logic              rsp_reused;
   logic [LIVE_W-1:0] rsp_live_blocks;
   logic [ADDR_W-1:0] rsp_bytes_allocated;
   logic [ADDR_W-1:0] rsp_bytes_freed;
   logic              csr_ready;

   // predicted allocator state
   logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
   logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
   bit                blk_used  [MAX_BLOCKS];
   int unsigned       blk_count      = 0;
   logic [ADDR_W-1:0] heap_top       = '0;
   logic [ADDR_W-1:0] heap_base_reg  = '0;
   logic [ADDR_W-1:0] heap_limit_reg = '1;
   int unsigned       live_count     = 0;
   logic [ADDR_W-1:0] alloc_sum      = '0;
   logic [ADDR_W-1:0] freed_sum      = '0;

   alloc_response_type expected_responses [$];

   int unsigned cycle_count       = 0;
   int unsigned failures          = 0;
   int unsigned burst_left        = 0;
   int unsigned requests_sent     = 0;
   int unsigned responses_checked = 0;
   int unsigned fresh_allocs      = 0;
   int unsigned reused_allocs     = 0;
   int unsigned frees_done        = 0;
   int unsigned no_space_count    = 0;
   int unsigned double_frees      = 0;
   int unsigned unknown_ptrs      = 0;

   first_fit_block_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_size           (req_size),
      .req_user_addr      (req_user_addr),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_grant_addr     (rsp_grant_addr),
      .rsp_reused         (rsp_reused),
      .rsp_live_blocks    (rsp_live_blocks),
      .rsp_bytes_allocated(rsp_bytes_allocated),
      .rsp_bytes_freed    (rsp_bytes_freed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] sat_sum(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ADDR_W] ? '1 : s[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] user_addr_of(input int unsigned idx);
      return blk_start[idx] + USER_OFS;
   endfunction

   // first-fit allocate or free against the predicted table
   function automatic alloc_response_type predict_response(input cmd_type           cmd,
                                                           input logic [SIZE_W-1:0] size,
                                                           input logic [ADDR_W-1:0] addr);
      alloc_response_type r;
      logic [ADDR_W:0] new_top;
      bit              found;
      r.status = STAT_OK;
      r.grant  = '0;
      r.reused = 1'b0;
      found    = 1'b0;
      if (cmd == CMD_ALLOC) begin
         for (int i = 0; i < blk_count; i++) begin
            if (!found && !blk_used[i] && size <= blk_size[i]) begin
               found       = 1'b1;
               blk_used[i] = 1'b1;
               blk_size[i] = size;
               live_count++;
               r.grant  = user_addr_of(i);
               r.reused = 1'b1;
            end
         end
         if (!found) begin
            new_top = {1'b0, heap_top} + BLOCK_OVERHEAD + size;
            if (blk_count >= MAX_BLOCKS || new_top > {1'b0, heap_limit_reg}) begin
               r.status = STAT_NO_SPACE;
            end else begin
               blk_start[blk_count] = heap_top;
               blk_size[blk_count]  = size;
               blk_used[blk_count]  = 1'b1;
               r.grant   = user_addr_of(blk_count);
               blk_count++;
               heap_top  = new_top[ADDR_W-1:0];
               alloc_sum = sat_sum(alloc_sum, ADDR_W'(size));
               live_count++;
            end
         end
      end else if (addr != '0) begin
         r.status = STAT_UNKNOWN_PTR;
         for (int i = 0; i < blk_count; i++) begin
            if (!found && ({1'b0, blk_start[i]} + USER_OFS) == {1'b0, addr}) begin
               found = 1'b1;
               if (!blk_used[i]) begin
                  r.status = STAT_DOUBLE_FREE;
               end else begin
                  r.status    = STAT_OK;
                  blk_used[i] = 1'b0;
                  freed_sum   = sat_sum(freed_sum, ADDR_W'(blk_size[i]));
                  if (live_count > 0) live_count--;
               end
            end
         end
      end
      r.live        = (live_count > 127) ? LIVE_W'(127) : LIVE_W'(live_count);
      r.bytes_alloc = alloc_sum;
      r.bytes_freed = freed_sum;
      return r;
   endfunction

   // send one request in bursts with random gaps, then record its prediction
   task automatic send_request(input cmd_type           cmd,
                               input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr);
      alloc_response_type want;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
      burst_left--;
      req_cmd       <= cmd;
      req_size      <= size;
      req_user_addr <= addr;
      start         <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      want = predict_response(cmd, size, addr);
      expected_responses.push_back(want);
      requests_sent++;
      if (cmd == CMD_ALLOC && want.status == STAT_OK) begin
         if (want.reused) reused_allocs++;
         else fresh_allocs++;
      end
      case (want.status)
         STAT_OK:          if (cmd == CMD_FREE && addr != '0) frees_done++;
         STAT_NO_SPACE:    no_space_count++;
         STAT_DOUBLE_FREE: double_frees++;
         STAT_UNKNOWN_PTR: unknown_ptrs++;
      endcase
   endtask

   task automatic request_alloc(input logic [SIZE_W-1:0] size);
      send_request(CMD_ALLOC, size, $urandom);
   endtask

   task automatic request_free(input logic [ADDR_W-1:0] addr);
      send_request(CMD_FREE, SIZE_W'($urandom), addr);
   endtask

   // hold off until every response is in and the table scan has settled
   task automatic wait_until_idle();
      start <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input reg_type idx, input logic [ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (idx)
         REG_HEAP_BASE: begin
            heap_base_reg = data;
            if (blk_count == 0) heap_top = data;
         end
         REG_HEAP_LIMIT: heap_limit_reg = data;
      endcase
      // csr_valid stays low before the next write
      @(posedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] random_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return SIZE_W'($urandom_range(0, 63));
      if (r < 85) return SIZE_W'($urandom_range(0, 4095));
      if (r < 95) return SIZE_W'($urandom);
      return $urandom_range(0, 1) ? '1 : '0;
   endfunction

   // table index, preferring entries whose in-use mark matches
   function automatic int unsigned pick_entry(input bit want_used);
      int unsigned first;
      int unsigned idx;
      first = $urandom_range(0, blk_count - 1);
      for (int unsigned k = 0; k < blk_count; k++) begin
         idx = (first + k) % blk_count;
         if (blk_used[idx] == want_used) return idx;
      end
      return first;
   endfunction

   // response checking
   function automatic void check_field(input string name, input logic [ADDR_W-1:0] want,
                                       input logic [ADDR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      alloc_response_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_responses.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = expected_responses.pop_front();
            responses_checked++;
            check_field("status", ADDR_W'(want.status), ADDR_W'(rsp_status));
            check_field("grant_addr", want.grant, rsp_grant_addr);
            check_field("reused", ADDR_W'(want.reused), ADDR_W'(rsp_reused));
            check_field("live_blocks", ADDR_W'(want.live), ADDR_W'(rsp_live_blocks));
            check_field("bytes_allocated", want.bytes_alloc, rsp_bytes_allocated);
            check_field("bytes_freed", want.bytes_freed, rsp_bytes_freed);
         end
      end
   end

   // empty table: zero limit, wrapping heap base, null and stray frees
   task automatic test_empty_heap();
      write_csr(REG_HEAP_LIMIT, '0);
      request_alloc('0);
      request_free('0);
      request_free($urandom | 32'h1);
      wait_until_idle();
      write_csr(REG_HEAP_BASE, '1);
      write_csr(REG_HEAP_LIMIT, '1);
      request_alloc('0);
      request_alloc('1);
      wait_until_idle();
      write_csr(REG_HEAP_BASE, 32'h0001_0000);
   endtask

   // fresh blocks, reuse with shrink, double free and unknown pointers
   task automatic test_alloc_free();
      request_alloc('0);
      request_alloc('1);
      request_alloc(SIZE_W'(100));
      request_free(user_addr_of(2));
      request_free(user_addr_of(2));
      request_free(user_addr_of(2) + 1);
      request_free(blk_start[2]);
      request_alloc(SIZE_W'(50));
      request_free(user_addr_of(2));
      request_alloc(SIZE_W'(80));
      request_free(user_addr_of(0));
      request_alloc('0);
   endtask

   // tight heap limit: a reused block, a fresh block within the limit, then one past it
   task automatic test_heap_limit();
      wait_until_idle();
      write_csr(REG_HEAP_LIMIT, heap_top + BLOCK_OVERHEAD + 10);
      request_alloc(SIZE_W'(10));
      request_alloc('0);
      request_alloc(SIZE_W'(11));
      wait_until_idle();
      write_csr(REG_HEAP_LIMIT, '1);
      // blocks exist, so only the register moves
      write_csr(REG_HEAP_BASE, '0);
      request_alloc(SIZE_W'(20));
   endtask

   // repeated free and reuse of the largest block drives the freed total to its ceiling
   task automatic test_counter_saturation();
      for (int unsigned n = 0; n < SAT_ROUNDS; n++) begin
         request_free(user_addr_of(1));
         request_alloc('1);
         if (n % 64 == 63) wait_until_idle();
      end
   endtask

   // fill every table entry, then allocations against the full table around one freed entry
   task automatic test_table_full();
      int unsigned idx;
      while (blk_count < MAX_BLOCKS) request_alloc(SIZE_W'($urandom_range(0, 255)));
      request_alloc('1);
      request_alloc(random_size());
      idx = pick_entry(1'b1);
      request_free(user_addr_of(idx));
      request_alloc(blk_size[idx] + 1'b1);
      request_alloc(blk_size[idx]);
   endtask

   // mixed traffic, mostly frees of live blocks and small allocations
   task automatic test_random_traffic(input int unsigned round);
      int unsigned r;
      wait_until_idle();
      case (round)
         0: write_csr(REG_HEAP_LIMIT, $urandom);
         1: write_csr(REG_HEAP_LIMIT, '0);
         2: write_csr(REG_HEAP_BASE, $urandom);
         default: begin
            write_csr(REG_HEAP_LIMIT, '1);
            write_csr(REG_HEAP_BASE, '1);
         end
      endcase
      for (int unsigned n = 0; n < ROUND_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         if (r < 50) request_alloc(random_size());
         else if (r < 80) request_free(user_addr_of(pick_entry(1'b1)));
         else if (r < 88) request_free(user_addr_of(pick_entry(1'b0)));
         else if (r < 91) request_free(blk_start[pick_entry(1'b1)]);
         else if (r < 95) request_free($urandom);
         else request_free('0);
         if ($urandom_range(0, 149) == 0) wait_until_idle();
      end
   endtask

   initial begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         blk_start[i] = '0;
         blk_size[i]  = '0;
         blk_used[i]  = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_heap();
      test_alloc_free();
      test_heap_limit();
      test_counter_saturation();
      test_table_full();
      for (int unsigned k = 0; k < RANDOM_ROUNDS; k++) test_random_traffic(k);
      wait_until_idle();
      $display("%0d requests, %0d responses checked: %0d fresh and %0d reused allocations,",
               requests_sent, responses_checked, fresh_allocs, reused_allocs);
      $display("%0d frees, %0d no-space, %0d double frees, %0d unknown pointers, freed 0x%0h",
               frees_done, no_space_count, double_frees, unknown_ptrs, freed_sum);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_ram.sv
hw/rtl/ffba_match.sv
hw/rtl/first_fit_block_allocator.sv
tb/tb.sv
